// File: design/prefix_suffix_word_search_defines.svh
// ---------------------------------------------------------------------------
// prefix suffix word search assertion macros
// clocked assertion helpers shared by the rtl files
// ---------------------------------------------------------------------------
`ifndef PREFIX_SUFFIX_WORD_SEARCH_DEFINES_SVH
`define PREFIX_SUFFIX_WORD_SEARCH_DEFINES_SVH

// checked only out of reset
`define PSSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define PSSW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/pssw_pkg.sv
// ---------------------------------------------------------------------------
// pssw_pkg
// shared types and constants of the prefix suffix word search block
// ---------------------------------------------------------------------------
package pssw_pkg;

  localparam int LETTER_W      = 5;
  localparam int NUM_LETTERS   = 10;
  localparam int CHARS_W       = LETTER_W * NUM_LETTERS;
  localparam int LEN_W         = 4;
  localparam int INDEX_W       = 14;
  localparam int MAX_WORDS_DEF = 16384;
  localparam int MAX_LEN_DEF   = 10;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [CHARS_W-1:0] word_chars;
    logic [LEN_W-1:0]   word_len;
    logic [CHARS_W-1:0] prefix_chars;
    logic [LEN_W-1:0]   prefix_len;
    logic [CHARS_W-1:0] suffix_chars;
    logic [LEN_W-1:0]   suffix_len;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
    logic               table_full;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic append;
    logic scan_start;
    logic scan_stop;
    logic hit_load;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_query;
    logic count_zero;
    logic hit;
    logic last;
  } dpath_status_t;

endpackage

// File: design/pssw_if.sv
// ---------------------------------------------------------------------------
// pssw stream interfaces
// valid/ready channels carrying one input item or one result item
// ---------------------------------------------------------------------------
interface pssw_in_if;
  import pssw_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pssw_out_if;
  import pssw_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/pssw_ram.sv
// ---------------------------------------------------------------------------
// pssw_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module pssw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/pssw_dpath.sv
// ---------------------------------------------------------------------------
// pssw_dpath
// word table, word count, scan pipeline, match logic and result registers
// ---------------------------------------------------------------------------
`include "prefix_suffix_word_search_defines.svh"

module pssw_dpath #(
  parameter int MAX_WORDS = pssw_pkg::MAX_WORDS_DEF,
  parameter int MAX_LEN   = pssw_pkg::MAX_LEN_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pssw_pkg::in_item_t      in_data,
  input  pssw_pkg::ctrl_cmd_t     cmd,
  output pssw_pkg::dpath_status_t st,
  output pssw_pkg::out_item_t     out_data
);
  import pssw_pkg::*;

  localparam int AW    = $clog2(MAX_WORDS);
  localparam int CW    = AW + 1;
  localparam int ENT_W = CHARS_W + LEN_W;

  // captured item
  logic [CHARS_W-1:0] q_word;
  logic [LEN_W-1:0]   q_wlen;
  logic [CHARS_W-1:0] q_pchars;
  logic [LEN_W-1:0]   q_plen;
  logic [CHARS_W-1:0] q_schars;
  logic [LEN_W-1:0]   q_slen;

  logic [CW-1:0] word_count;
  logic          table_is_full;

  // scan pipeline
  logic          issue_on;
  logic [AW-1:0] rd_addr;
  logic          s1_valid;
  logic [AW-1:0] s1_idx;
  logic          s2_valid;
  logic          s2_hit;
  logic [AW-1:0] s2_idx;

  logic             wr_en;
  logic [ENT_W-1:0] ram_q;

  logic [CHARS_W-1:0] ent_word;
  logic [LEN_W-1:0]   ent_len;
  logic [LEN_W-1:0]   suf_off;
  logic [CHARS_W-1:0] ent_shift;
  logic               pre_ok;
  logic               suf_ok;
  logic               ent_match;

  logic          res_found;
  logic [AW-1:0] res_index;
  logic          res_full;

  logic [LEN_W-1:0] len_sat;

  assign table_is_full = (word_count >= CW'(MAX_WORDS));
  assign len_sat = (in_data.word_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_data.word_len;
  assign wr_en = cmd.append && !table_is_full;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_word   <= in_data.word_chars;
      q_wlen   <= len_sat;
      q_pchars <= in_data.prefix_chars;
      q_plen   <= in_data.prefix_len;
      q_schars <= in_data.suffix_chars;
      q_slen   <= in_data.suffix_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (wr_en) begin
      word_count <= word_count + CW'(1);
    end
  end

  pssw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WORDS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (word_count[AW-1:0]),
    .wdata ({q_wlen, q_word}),
    .re    (issue_on),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // read issue, highest index first
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_on <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (cmd.scan_stop) begin
      issue_on <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        issue_on <= 1'b1;
      end else if (issue_on && rd_addr == '0) begin
        issue_on <= 1'b0;
      end
      s1_valid <= issue_on;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_addr <= AW'(word_count - CW'(1));
    end else if (issue_on) begin
      rd_addr <= rd_addr - AW'(1);
    end
    s1_idx <= rd_addr;
    s2_idx <= s1_idx;
    s2_hit <= ent_match;
  end

  // entry compare
  assign ent_word  = ram_q[CHARS_W-1:0];
  assign ent_len   = ram_q[CHARS_W +: LEN_W];
  assign suf_off   = ent_len - q_slen;
  assign ent_shift = ent_word >> (7'(suf_off) * 7'(LETTER_W));

  always_comb begin
    pre_ok = 1'b1;
    suf_ok = 1'b1;
    for (int k = 0; k < NUM_LETTERS; k++) begin
      if (LEN_W'(k) < q_plen &&
          q_pchars[LETTER_W*k +: LETTER_W] != ent_word[LETTER_W*k +: LETTER_W]) begin
        pre_ok = 1'b0;
      end
      if (LEN_W'(k) < q_slen &&
          q_schars[LETTER_W*k +: LETTER_W] != ent_shift[LETTER_W*k +: LETTER_W]) begin
        suf_ok = 1'b0;
      end
    end
  end

  assign ent_match = (q_plen <= ent_len) && (q_slen <= ent_len) && pre_ok && suf_ok;

  // result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_found <= 1'b0;
      res_index <= '0;
      res_full  <= 1'b0;
    end else if (cmd.append) begin
      res_found <= !table_is_full;
      res_index <= table_is_full ? '0 : word_count[AW-1:0];
      res_full  <= table_is_full;
    end else if (cmd.hit_load) begin
      res_found <= 1'b1;
      res_index <= s2_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.found       <= res_found;
      out_data.match_index <= INDEX_W'(res_index);
      out_data.table_full  <= res_full;
    end
  end

  assign st.in_query   = (in_data.func == FUNC_QUERY);
  assign st.count_zero = (word_count == '0);
  assign st.hit        = s2_valid && s2_hit;
  assign st.last       = s2_valid && (s2_idx == '0);

  `PSSW_ASSERT(a_count_bounded, word_count <= CW'(MAX_WORDS), "word count past table size")
  `PSSW_ASSERT(a_append_counts, wr_en |=> word_count == $past(word_count) + CW'(1), "append lost")
  `PSSW_ASSERT(a_scan_in_table, s2_valid |-> CW'(s2_idx) < word_count, "scan outside written words")

endmodule

// File: design/pssw_ctrl.sv
// ---------------------------------------------------------------------------
// pssw_ctrl
// sequencer for append, table scan and result hand-off
// ---------------------------------------------------------------------------
`include "prefix_suffix_word_search_defines.svh"

module pssw_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  pssw_pkg::dpath_status_t st,
  output pssw_pkg::ctrl_cmd_t     cmd
);
  import pssw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_APPEND = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   in_fire;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          if (!st.in_query) begin
            state_next = S_APPEND;
          end else if (st.count_zero) begin
            state_next = S_FINISH;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_FINISH;
      end
      S_SCAN: begin
        if (st.hit) begin
          cmd.hit_load  = 1'b1;
          cmd.scan_stop = 1'b1;
          state_next    = S_FINISH;
        end else if (st.last) begin
          cmd.scan_stop = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `PSSW_ASSERT(a_accept_leaves_idle, in_fire |=> state != S_IDLE, "transfer did not start work")
  `PSSW_ASSERT(a_hit_in_scan, st.hit |-> state == S_SCAN, "match seen outside scan")
  `PSSW_ASSERT(a_result_from_finish, $rose(out_valid) |-> $past(state == S_FINISH), "stray result")

endmodule

// File: design/prefix_suffix_word_search.sv
// ---------------------------------------------------------------------------
// prefix_suffix_word_search
// word table with append and highest-index prefix plus suffix lookup
// ---------------------------------------------------------------------------
//  port     dir   payload
//  in_ch    sink  func, word, prefix and suffix letters with lengths
//  out_ch   src   found, match_index, table_full
//
//  append: transfer captured in idle, result register loaded in the append state
//  query: one table entry read per cycle through the single ram read port,
//    from the highest index down, until a match or the entry at index zero
//  reset clears the word count and control state, no clearing pass over the table
//  a waiting result does not block the next input transfer
// ---------------------------------------------------------------------------
module prefix_suffix_word_search #(
  parameter int MAX_WORDS = pssw_pkg::MAX_WORDS_DEF,
  parameter int MAX_LEN   = pssw_pkg::MAX_LEN_DEF
) (
  input logic       clk,
  input logic       rst,
  pssw_in_if.sink   in_ch,
  pssw_out_if.source out_ch
);
  import pssw_pkg::*;

  ctrl_cmd_t     cmd;
  dpath_status_t st;

  pssw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  pssw_dpath #(
    .MAX_WORDS (MAX_WORDS),
    .MAX_LEN   (MAX_LEN)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_ch.data)
  );

endmodule
